[rtl/core/cfrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfrc_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte step for the framed
// command receiver.
// ----------------------------------------------------------------------------
package cfrc_pkg;

	// Event kinds on the input channel
	localparam logic [1:0] EV_BYTE  = 2'd0;
	localparam logic [1:0] EV_ERROR = 2'd1;
	localparam logic [1:0] EV_TICK  = 2'd2;

	// Result kinds on the output channel
	localparam logic [2:0] RK_PAYLOAD  = 3'd0;
	localparam logic [2:0] RK_FRAME_OK = 3'd1;
	localparam logic [2:0] RK_PLAIN    = 3'd2;
	localparam logic [2:0] RK_SERIAL   = 3'd3;
	localparam logic [2:0] RK_TIMEOUT  = 3'd4;
	localparam logic [2:0] RK_CRC_ERR  = 3'd5;
	localparam logic [2:0] RK_ADDR_ERR = 3'd6;

	// Configuration register indexes
	localparam logic [2:0] CFG_BEGIN_CODE = 3'd0;
	localparam logic [2:0] CFG_ERASE_CODE = 3'd1;
	localparam logic [2:0] CFG_WRITE_CODE = 3'd2;
	localparam logic [2:0] CFG_CHECK_CODE = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT    = 3'd4;
	localparam logic [2:0] CFG_APP_START  = 3'd5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// Default geometry
	localparam int PAGE_BYTES_DEF  = 512;
	localparam int FLASH_BYTES_DEF = 131072;

	// Address bits that can hold a valid page address (flash is at most 16 MiB)
	localparam int ADDR_W  = 24;
	// Reciprocal width for the page-size division
	localparam int RECIP_W = ADDR_W + 2;
	// Frame body counter, holds a page index up to 1023
	localparam int COUNT_W = 10;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [7:0] error_bits;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [7:0]  command_byte;
		logic [31:0] first_word;
		logic [31:0] second_word;
		logic [7:0]  payload_byte;
		logic [8:0]  payload_index;
		logic [15:0] payload_crc;
		logic [7:0]  line_error_bits;
	} result_t;

	// One byte of CRC-16/CCITT-FALSE, MSB first
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] v);
		logic [15:0] c;
		c = crc ^ {v, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[rtl/core/command_frame_receiver_crc16_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_receiver_crc16_top
// Framed serial command receiver: command byte, little-endian address or
// image words, optional payload page, CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// The block takes one event beat per clock (received byte, line error or
// millisecond tick) while its result register is free or being taken, and
// returns at most one result beat per event, in order. Each beat passes
// through the input register and then the result register; the CRC byte step
// and the frame decode sit between those two registers. Page alignment of an
// address is checked with a reciprocal product registered from the address
// register; the two trailer bytes always give it time to update.
// Configuration is written through a plain write port and must only change
// while no frame is in flight.
// ----------------------------------------------------------------------------
module command_frame_receiver_crc16_top
	import cfrc_pkg::*;
#(
	parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
	parameter int FLASH_BYTES = FLASH_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Frame phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_WORD1   = 3'd1;
	localparam logic [2:0] PH_WORD2   = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CRCLO   = 3'd4;
	localparam logic [2:0] PH_CRCHI   = 3'd5;

	// Frame types
	localparam logic [2:0] FT_NONE  = 3'd0;
	localparam logic [2:0] FT_BEGIN = 3'd1;
	localparam logic [2:0] FT_ERASE = 3'd2;
	localparam logic [2:0] FT_WRITE = 3'd3;
	localparam logic [2:0] FT_CHECK = 3'd4;

	// Division by the page size: floor(a / P) = (a * RECIP) >> RECIP_SHIFT
	localparam int PG_LOG      = $clog2(PAGE_BYTES);
	localparam int RECIP_SHIFT = ADDR_W + PG_LOG;
	localparam int PROD_W      = ADDR_W + RECIP_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
	localparam logic [RECIP_W-1:0] RECIP     = RECIP_FULL[RECIP_W-1:0];
	localparam logic [31:0]        ADDR_MAX  = 32'(FLASH_BYTES - PAGE_BYTES);
	localparam logic [COUNT_W-1:0] PAGE_LAST = COUNT_W'(PAGE_BYTES - 1);

	// Configuration registers
	logic [7:0]  begin_code_q, erase_code_q, write_code_q, check_code_q;
	logic [15:0] timeout_q;
	logic [17:0] app_start_q;

	// Frame state
	logic [2:0]         phase_q, phase_d;
	logic [2:0]         ftype_q, ftype_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [15:0]        run_crc_q, run_crc_d;
	logic [15:0]        page_crc_q, page_crc_d;
	logic [31:0]        word_one_q, word_one_d;
	logic [31:0]        word_two_q, word_two_d;
	logic [7:0]         cmd_q, cmd_d;
	logic [7:0]         exp_lo_q, exp_lo_d;
	logic [15:0]        ticks_q, ticks_d;
	logic [ADDR_W-1:0]  quot_q;

	// Pipeline
	logic     valid_s1;
	in_item_t item_s1;
	logic     advance;
	logic     emit;
	result_t  res;
	logic     out_valid_q;
	result_t  result_q;

	// Handshake: the input register moves on whenever the result register frees
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = result_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_code_q <= 8'd66;
			erase_code_q <= 8'd69;
			write_code_q <= 8'd87;
			check_code_q <= 8'd67;
			timeout_q    <= 16'd100;
			app_start_q  <= 18'd16384;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BEGIN_CODE: begin_code_q <= cfg_wdata[7:0];
				CFG_ERASE_CODE: erase_code_q <= cfg_wdata[7:0];
				CFG_WRITE_CODE: write_code_q <= cfg_wdata[7:0];
				CFG_CHECK_CODE: check_code_q <= cfg_wdata[7:0];
				CFG_TIMEOUT:    timeout_q    <= cfg_wdata[15:0];
				CFG_APP_START:  app_start_q  <= cfg_wdata[17:0];
				default: ;
			endcase
		end
	end

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// Track floor(address / page size); one multiply, registered
	logic [PROD_W-1:0] quot_prod;
	assign quot_prod = PROD_W'(word_one_q[ADDR_W-1:0]) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		quot_q <= ADDR_W'(quot_prod >> RECIP_SHIFT);
	end

	// Address check for erase, write and check frames
	logic addr_ok;
	logic page_aligned;
	assign page_aligned = (word_one_q[31:ADDR_W] == '0) &&
		(word_one_q[ADDR_W-1:0] == ADDR_W'(quot_q * ADDR_W'(PAGE_BYTES)));
	assign addr_ok = page_aligned && (word_one_q >= 32'(app_start_q)) &&
		(word_one_q <= ADDR_MAX) && (FLASH_BYTES >= PAGE_BYTES);

	// Frame decode: next state and result for the beat in the input register
	logic [15:0] run_crc_step;
	logic [15:0] open_crc;
	logic [15:0] page_crc_step;
	logic [15:0] ticks_inc;
	logic [15:0] exp_crc;
	logic [2:0]  open_type;
	logic [4:0]  shift_amt;

	assign run_crc_step  = crc16_step(run_crc_q, item_s1.data_byte);
	assign open_crc      = crc16_step(CRC_INIT, item_s1.data_byte);
	assign page_crc_step = crc16_step(page_crc_q, item_s1.data_byte);
	assign ticks_inc     = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
	assign exp_crc       = {item_s1.data_byte, exp_lo_q};
	assign shift_amt     = {count_q[1:0], 3'b000};

	always_comb begin
		if (item_s1.data_byte == begin_code_q) begin
			open_type = FT_BEGIN;
		end else if (item_s1.data_byte == erase_code_q) begin
			open_type = FT_ERASE;
		end else if (item_s1.data_byte == write_code_q) begin
			open_type = FT_WRITE;
		end else if (item_s1.data_byte == check_code_q) begin
			open_type = FT_CHECK;
		end else begin
			open_type = FT_NONE;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		ftype_d    = ftype_q;
		count_d    = count_q;
		run_crc_d  = run_crc_q;
		page_crc_d = page_crc_q;
		word_one_d = word_one_q;
		word_two_d = word_two_q;
		cmd_d      = cmd_q;
		exp_lo_d   = exp_lo_q;
		ticks_d    = ticks_q;
		emit       = 1'b0;
		res        = '0;

		case (item_s1.kind)
			EV_ERROR: begin
				// Nonzero flags abort any frame
				if (item_s1.error_bits != 8'd0) begin
					emit                = 1'b1;
					res.result_kind     = RK_SERIAL;
					res.command_byte    = (phase_q == PH_IDLE) ? 8'd0 : cmd_q;
					res.line_error_bits = item_s1.error_bits;
					phase_d = PH_IDLE;
					ftype_d = FT_NONE;
					count_d = '0;
					ticks_d = '0;
				end
			end
			EV_TICK: begin
				// Count ticks inside a frame, abort at the limit
				if (phase_q != PH_IDLE) begin
					ticks_d = ticks_inc;
					if (ticks_inc >= timeout_q) begin
						emit             = 1'b1;
						res.result_kind  = RK_TIMEOUT;
						res.command_byte = cmd_q;
						phase_d = PH_IDLE;
						ftype_d = FT_NONE;
						count_d = '0;
						ticks_d = '0;
					end
				end
			end
			EV_BYTE: begin
				if (phase_q == PH_IDLE) begin
					if (open_type == FT_NONE) begin
						// Pass through
						emit             = 1'b1;
						res.result_kind  = RK_PLAIN;
						res.command_byte = item_s1.data_byte;
					end else begin
						// Open a frame
						ftype_d    = open_type;
						cmd_d      = item_s1.data_byte;
						run_crc_d  = open_crc;
						page_crc_d = CRC_INIT;
						word_one_d = '0;
						word_two_d = '0;
						exp_lo_d   = '0;
						count_d    = '0;
						ticks_d    = '0;
						phase_d    = PH_WORD1;
					end
				end else begin
					ticks_d = '0;
					case (phase_q)
						PH_WORD1, PH_WORD2: begin
							// Assemble a little-endian word
							run_crc_d = run_crc_step;
							if (phase_q == PH_WORD1) begin
								word_one_d = word_one_q | (32'(item_s1.data_byte) << shift_amt);
							end else begin
								word_two_d = word_two_q | (32'(item_s1.data_byte) << shift_amt);
							end
							count_d = count_q + COUNT_W'(1);
							if (count_q[1:0] == 2'd3) begin
								count_d = '0;
								if (phase_q == PH_WORD1 && ftype_q == FT_BEGIN) begin
									phase_d = PH_WORD2;
								end else if (phase_q == PH_WORD1 && ftype_q == FT_WRITE) begin
									phase_d = PH_PAYLOAD;
								end else begin
									phase_d = PH_CRCLO;
								end
							end
						end
						PH_PAYLOAD: begin
							// Emit the payload byte with its index
							run_crc_d  = run_crc_step;
							page_crc_d = page_crc_step;
							emit              = 1'b1;
							res.result_kind   = RK_PAYLOAD;
							res.command_byte  = cmd_q;
							res.first_word    = word_one_q;
							res.payload_byte  = item_s1.data_byte;
							res.payload_index = count_q[8:0];
							if (count_q == PAGE_LAST) begin
								count_d = '0;
								phase_d = PH_CRCLO;
							end else begin
								count_d = count_q + COUNT_W'(1);
							end
						end
						PH_CRCLO: begin
							exp_lo_d = item_s1.data_byte;
							phase_d  = PH_CRCHI;
						end
						default: begin
							// Trailer complete: report the frame
							emit             = 1'b1;
							res.command_byte = cmd_q;
							res.first_word   = word_one_q;
							res.second_word  = (ftype_q == FT_BEGIN) ? word_two_q : 32'd0;
							if (run_crc_q != exp_crc) begin
								res.result_kind = RK_CRC_ERR;
							end else if (ftype_q != FT_BEGIN && !addr_ok) begin
								res.result_kind = RK_ADDR_ERR;
							end else begin
								res.result_kind = RK_FRAME_OK;
								res.payload_crc = (ftype_q == FT_WRITE) ? page_crc_q : 16'd0;
							end
							exp_lo_d = item_s1.data_byte;
							phase_d  = PH_IDLE;
							ftype_d  = FT_NONE;
							count_d  = '0;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// Advance frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			ftype_q    <= FT_NONE;
			count_q    <= '0;
			run_crc_q  <= CRC_INIT;
			page_crc_q <= CRC_INIT;
			word_one_q <= '0;
			word_two_q <= '0;
			cmd_q      <= '0;
			exp_lo_q   <= '0;
			ticks_q    <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			ftype_q    <= ftype_d;
			count_q    <= count_d;
			run_crc_q  <= run_crc_d;
			page_crc_q <= page_crc_d;
			word_one_q <= word_one_d;
			word_two_q <= word_two_d;
			cmd_q      <= cmd_d;
			exp_lo_q   <= exp_lo_d;
			ticks_q    <= ticks_d;
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= res;
		end
	end

	// Tick counter only runs inside a frame
	a_idle_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> ticks_q == 16'd0)
		else $error("tick counter nonzero while idle");

	// Word assembly counter stays within one word
	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WORD1 || phase_q == PH_WORD2) |-> count_q < COUNT_W'(4))
		else $error("word byte counter out of range");

	// Payload results only come from the payload phase of a write frame
	a_payload_src: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && res.result_kind == RK_PAYLOAD) |->
			(phase_q == PH_PAYLOAD && ftype_q == FT_WRITE))
		else $error("payload beat outside a write frame");

	// An open frame always has a type
	a_frame_type: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (ftype_q != FT_NONE))
		else $error("frame open without a type");

endmodule
